// ===== hdl/assert_macros.svh =====
// Assertion macros for the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("console assertion failed");
// Expression is never true at a clock edge outside reset.
`define TCW_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("console forbidden condition seen");
`else
`define TCW_ASSERT(lbl, clk, rstn, prop)
`define TCW_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hdl/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

	// Default geometry
	localparam int DEF_COLS      = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TERMINALS = 3;

	// Result field widths
	localparam int ROW_FW = 5;
	localparam int COL_FW = 7;
	localparam int POS_FW = 11;

	// Command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_BACK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Characters
	localparam logic [7:0] CHAR_BLANK = 8'h20;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// Per-terminal attributes
	localparam logic [7:0] ATTR_T0 = 8'h07;
	localparam logic [7:0] ATTR_T1 = 8'h10;
	localparam logic [7:0] ATTR_T2 = 8'h20;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] terminal;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        scrolled;
	} rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_req;
		logic exec;
		logic sweep_start;
		logic sweep_copy;
		logic sweep_all;
		logic cell_cap;
		logic load_out;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic term_ok;
		logic is_clear;
		logic is_read;
		logic need_scroll;
		logic sweep_busy;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] attr_of(input logic [1:0] term);
		logic [7:0] a;
		case (term)
			2'd0:    a = ATTR_T0;
			2'd1:    a = ATTR_T1;
			2'd2:    a = ATTR_T2;
			default: a = ATTR_T0;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath: request register, cursors, screen memory, sweep engine, result register.
`include "assert_macros.svh"
module tcw_dp import tcw_pkg::*; #(
	parameter int COLS      = DEF_COLS,
	parameter int ROWS      = DEF_ROWS,
	parameter int TERMINALS = DEF_TERMINALS
) (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	output sts_t sts,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int RW        = $clog2(ROWS);
	localparam int CW        = $clog2(COLS);
	localparam int TW        = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam int PW        = RW + CW;
	localparam int MEM_DEPTH = TERMINALS * (2 ** (RW + CW));
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	req_t          req_q;
	logic [TW-1:0] tix;
	logic          term_ok;
	logic [RW-1:0] row_q [TERMINALS];
	logic [CW-1:0] col_q [TERMINALS];
	logic [RW-1:0] cur_row;
	logic [CW-1:0] cur_col;
	logic          is_nl;
	logic          col_last;
	logic          row_last;
	logic          at_origin;
	logic          wrap;
	logic [RW-1:0] nrow;
	logic [CW-1:0] ncol;
	logic [RW-1:0] st_row;
	logic [CW-1:0] st_col;
	logic          step_we;
	logic [7:0]    step_data;
	logic          rd_ok;
	logic          scrolled_q;
	logic [7:0]    cell_q;

	logic          sw_act_q;
	logic          sw_copy_q;
	logic          sw_all_q;
	logic [TW-1:0] sw_term_q;
	logic [RW-1:0] sw_row_q;
	logic [CW-1:0] sw_col_q;
	logic          sw_col_end;
	logic          sw_row_end;
	logic          sw_term_end;

	logic              wr_vld_s1;
	logic              wr_blank_s1;
	logic [MEM_AW-1:0] wr_addr_s1;

	logic              ram_we;
	logic [MEM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [MEM_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	logic [PW-1:0] pos;
	rsp_t          rsp_next;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_q <= req;
		end
	end

	assign tix     = TW'(req_q.terminal);
	assign term_ok = int'(req_q.terminal) < TERMINALS;
	assign cur_row = row_q[tix];
	assign cur_col = col_q[tix];
	assign rd_ok   = (int'(req_q.read_row) < ROWS) && (int'(req_q.read_col) < COLS);

	assign is_nl     = (req_q.char_code == CHAR_NL) || (req_q.char_code == CHAR_CR);
	assign col_last  = cur_col == CW'(COLS - 1);
	assign row_last  = cur_row == RW'(ROWS - 1);
	assign at_origin = (cur_row == '0) && (cur_col == '0);
	assign wrap      = is_nl || col_last;

	// Next cursor and cell write for one command
	always_comb begin
		nrow      = cur_row;
		ncol      = cur_col;
		st_row    = cur_row;
		st_col    = cur_col;
		step_we   = 1'b0;
		step_data = CHAR_BLANK;
		unique case (req_q.cmd)
			CMD_PUT: begin
				step_we   = !is_nl;
				step_data = req_q.char_code;
				if (wrap) begin
					ncol = '0;
					if (!row_last) begin
						nrow = cur_row + RW'(1);
					end
				end else begin
					ncol = cur_col + CW'(1);
				end
			end
			CMD_BACK: begin
				if (!at_origin) begin
					step_we = 1'b1;
					if (cur_col == '0) begin
						nrow = cur_row - RW'(1);
						ncol = CW'(COLS - 1);
					end else begin
						ncol = cur_col - CW'(1);
					end
					st_row = nrow;
					st_col = ncol;
				end
			end
			CMD_CLEAR: begin
				nrow = '0;
				ncol = '0;
			end
			CMD_READ: begin
			end
		endcase
	end

	// Update the cursor of the addressed terminal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMINALS; i++) begin
				row_q[i] <= '0;
				col_q[i] <= '0;
			end
		end else if (ctl.exec && term_ok) begin
			row_q[tix] <= nrow;
			col_q[tix] <= ncol;
		end
	end

	// Scroll flag and read cell
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			scrolled_q <= 1'b0;
			cell_q     <= '0;
		end else begin
			if (ctl.exec) begin
				scrolled_q <= sts.need_scroll;
			end
			if (ctl.cell_cap) begin
				cell_q <= rd_ok ? ram_rdata : '0;
			end
		end
	end

	// Sweep engine: copy rows up or blank cells, one cell a cycle
	assign sw_col_end  = sw_col_q == CW'(COLS - 1);
	assign sw_row_end  = sw_row_q == RW'(ROWS - 1);
	assign sw_term_end = !sw_all_q || (sw_term_q == TW'(TERMINALS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_act_q <= 1'b0;
		end else if (ctl.sweep_start) begin
			sw_act_q <= 1'b1;
		end else if (sw_act_q && sw_col_end && sw_row_end && sw_term_end) begin
			sw_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sweep_start) begin
			sw_term_q <= ctl.sweep_all ? '0 : tix;
			sw_row_q  <= '0;
			sw_col_q  <= '0;
			sw_copy_q <= ctl.sweep_copy;
			sw_all_q  <= ctl.sweep_all;
		end else if (sw_act_q) begin
			if (sw_col_end) begin
				sw_col_q <= '0;
				if (sw_row_end) begin
					sw_row_q <= '0;
					if (!sw_term_end) begin
						sw_term_q <= sw_term_q + TW'(1);
					end
				end else begin
					sw_row_q <= sw_row_q + RW'(1);
				end
			end else begin
				sw_col_q <= sw_col_q + CW'(1);
			end
		end
	end

	// Write stage of the sweep, in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= sw_act_q;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1  <= MEM_AW'({sw_term_q, sw_row_q, sw_col_q});
		wr_blank_s1 <= !sw_copy_q || sw_row_end;
	end

	// Memory port selection
	assign ram_we    = (ctl.exec && term_ok && step_we) || wr_vld_s1;
	assign ram_waddr = ctl.exec ? MEM_AW'({tix, st_row, st_col}) : wr_addr_s1;
	assign ram_wdata = ctl.exec ? step_data : (wr_blank_s1 ? CHAR_BLANK : ram_rdata);
	assign ram_raddr = sw_act_q ? MEM_AW'({sw_term_q, sw_row_q + RW'(1), sw_col_q})
		: MEM_AW'({tix, RW'(req_q.read_row), CW'(req_q.read_col)});

	tcw_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Assemble the result
	assign pos = PW'(cur_row) * PW'(COLS) + PW'(cur_col);

	always_comb begin
		rsp_next = '0;
		if (term_ok) begin
			rsp_next.cursor_row      = ROW_FW'(cur_row);
			rsp_next.cursor_col      = COL_FW'(cur_col);
			rsp_next.cursor_position = POS_FW'(pos);
			rsp_next.cell_char       = cell_q;
			rsp_next.cell_attr       = attr_of(req_q.terminal);
			rsp_next.scrolled        = scrolled_q;
		end
	end

	// Result register, freed when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller
	assign sts.term_ok     = term_ok;
	assign sts.is_clear    = req_q.cmd == CMD_CLEAR;
	assign sts.is_read     = req_q.cmd == CMD_READ;
	assign sts.need_scroll = term_ok && (req_q.cmd == CMD_PUT) && wrap && row_last;
	assign sts.sweep_busy  = sw_act_q || wr_vld_s1;
	assign sts.out_free    = !rsp_valid_q || !rsp_stall;

	`TCW_NEVER(a_wr_clash, clk, arst_n, ctl.exec && wr_vld_s1)
	`TCW_NEVER(a_sweep_restart, clk, arst_n, ctl.sweep_start && (sw_act_q || wr_vld_s1))
	`TCW_ASSERT(a_load_free, clk, arst_n, ctl.load_out |-> (!rsp_valid_q || !rsp_stall))
	`TCW_ASSERT(a_scroll_col0, clk, arst_n, (rsp_valid_q && rsp_q.scrolled) |-> (rsp_q.cursor_col == '0))
	`TCW_ASSERT(a_col_range, clk, arst_n, rsp_valid_q |-> (int'(rsp_q.cursor_col) < COLS))

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller state machine: sequences execute, sweep, fetch and result steps.
module tcw_ctrl import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_INITW  = 3'd1;
	localparam logic [2:0] S_IDLE   = 3'd2;
	localparam logic [2:0] S_EXEC   = 3'd3;
	localparam logic [2:0] S_FETCH  = 3'd4;
	localparam logic [2:0] S_SWEEP  = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and commands
	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_INIT: begin
				ctl.sweep_start = 1'b1;
				ctl.sweep_all   = 1'b1;
				state_nxt       = S_INITW;
			end
			S_INITW: begin
				if (!sts.sweep_busy) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load_req = 1'b1;
					state_nxt    = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (!sts.term_ok) begin
					state_nxt = S_RESULT;
				end else if (sts.is_clear) begin
					ctl.sweep_start = 1'b1;
					state_nxt       = S_SWEEP;
				end else if (sts.need_scroll) begin
					ctl.sweep_start = 1'b1;
					ctl.sweep_copy  = 1'b1;
					state_nxt       = S_SWEEP;
				end else if (sts.is_read) begin
					state_nxt = S_FETCH;
				end else begin
					state_nxt = S_RESULT;
				end
			end
			S_FETCH: begin
				ctl.cell_cap = 1'b1;
				state_nxt    = S_RESULT;
			end
			S_SWEEP: begin
				if (!sts.sweep_busy) begin
					state_nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hdl/text_console_writer.sv =====
// Put, backspace, newline without scroll: the request is executed, then the result loaded;
// read cell: a fetch from the screen memory comes between; scroll or clear: a sweep of the
// terminal's screen comes between, one cell per cycle through the single write port of the
// screen memory. One request in flight at a time; the next request is taken in the cycle
// after the result is loaded. Reset: cursors go to the origin, then a blanking pass writes a
// space to every cell of every terminal, req_stall held high until the pass ends.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLS      = DEF_COLS,
	parameter int ROWS      = DEF_ROWS,
	parameter int TERMINALS = DEF_TERMINALS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	tcw_dp #(
		.COLS      (COLS),
		.ROWS      (ROWS),
		.TERMINALS (TERMINALS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== verif/text_console_writer_tb.sv =====
// Self-checking testbench for the multi-terminal text console writer.
`timescale 1ns / 100ps

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int COLS        = DEF_COLS;
	localparam int ROWS        = DEF_ROWS;
	localparam int TERMS       = DEF_TERMINALS;
	localparam int IDLE_PCT    = 37;
	localparam int RANDOM_REQS = 300;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t pending_reqs[$];
	rsp_t due_rsps[$];
	int req_taken = 0;
	int fail_count = 0;
	int cycle_count = 0;
	logic calm;

	// Shadow copy of every screen and cursor
	logic [7:0] shadow_chars [TERMS][ROWS][COLS];
	int shadow_row [TERMS];
	int shadow_col [TERMS];

	text_console_writer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Generate the clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold both sides busy for a stretch of requests
	assign calm = (req_taken >= 120) && (req_taken < 180);

	// Advance the cursor one row, scrolling the screen at the bottom
	function automatic logic console_next_row(input int t);
		int rw, cl;
		shadow_row[t]++;
		if (shadow_row[t] < ROWS)
			return 1'b0;
		for (rw = 0; rw < ROWS - 1; rw++)
			for (cl = 0; cl < COLS; cl++)
				shadow_chars[t][rw][cl] = shadow_chars[t][rw + 1][cl];
		for (cl = 0; cl < COLS; cl++)
			shadow_chars[t][ROWS - 1][cl] = CHAR_BLANK;
		shadow_row[t] = ROWS - 1;
		return 1'b1;
	endfunction

	// Apply one request to the shadow screens and return the cursor report
	function automatic rsp_t console_apply(input req_t r);
		rsp_t o;
		int t, rw, cl;
		logic [7:0] cell_val;
		logic rolled;
		o = '0;
		cell_val = 8'h00;
		rolled = 1'b0;
		t = int'(r.terminal);
		if (t >= TERMS)
			return o;
		case (r.cmd)
			CMD_PUT: begin
				if (r.char_code == CHAR_NL || r.char_code == CHAR_CR) begin
					rolled = console_next_row(t);
					shadow_col[t] = 0;
				end else begin
					shadow_chars[t][shadow_row[t]][shadow_col[t]] = r.char_code;
					shadow_col[t]++;
					if (shadow_col[t] >= COLS) begin
						shadow_col[t] = 0;
						rolled = console_next_row(t);
					end
				end
			end
			CMD_BACK: begin
				// Ignore backspace at the origin
				if (shadow_col[t] != 0 || shadow_row[t] != 0) begin
					if (shadow_col[t] == 0) begin
						shadow_row[t]--;
						shadow_col[t] = COLS - 1;
					end else begin
						shadow_col[t]--;
					end
					shadow_chars[t][shadow_row[t]][shadow_col[t]] = CHAR_BLANK;
				end
			end
			CMD_CLEAR: begin
				for (rw = 0; rw < ROWS; rw++)
					for (cl = 0; cl < COLS; cl++)
						shadow_chars[t][rw][cl] = CHAR_BLANK;
				shadow_row[t] = 0;
				shadow_col[t] = 0;
			end
			default: begin
				if (int'(r.read_row) < ROWS && int'(r.read_col) < COLS)
					cell_val = shadow_chars[t][r.read_row][r.read_col];
			end
		endcase
		rw = shadow_row[t];
		cl = shadow_col[t];
		o.cursor_row = rw[ROW_FW-1:0];
		o.cursor_col = cl[COL_FW-1:0];
		o.cursor_position = POS_FW'(rw * COLS + cl);
		o.cell_char = cell_val;
		case (t)
			0:       o.cell_attr = ATTR_T0;
			1:       o.cell_attr = ATTR_T1;
			2:       o.cell_attr = ATTR_T2;
			default: o.cell_attr = ATTR_T0;
		endcase
		o.scrolled = rolled;
		return o;
	endfunction

	task automatic queue_item(input int c, input int trm, input int ch, input int rr,
			input int rc);
		req_t item;
		item.cmd = 2'(c);
		item.terminal = 2'(trm);
		item.char_code = 8'(ch);
		item.read_row = 5'(rr);
		item.read_col = 7'(rc);
		pending_reqs.push_back(item);
	endtask

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: expected row %0d col %0d pos %0d char %h attr %h scr %0b,",
				$realtime, what, want.cursor_row, want.cursor_col, want.cursor_position,
				want.cell_char, want.cell_attr, want.scrolled,
				" got row %0d col %0d pos %0d char %h attr %h scr %0b",
				got.cursor_row, got.cursor_col, got.cursor_position, got.cell_char,
				got.cell_attr, got.scrolled);
	endtask

	// Drive requests; predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				due_rsps.push_back(console_apply(req));
				req_taken++;
			end
			if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Check each taken response against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsps.size() == 0) begin
					note_mismatch("unexpected response", '0, rsp);
				end else begin
					want = due_rsps.pop_front();
					if (rsp.cursor_row !== want.cursor_row
							|| rsp.cursor_col !== want.cursor_col
							|| rsp.cursor_position !== want.cursor_position
							|| rsp.cell_char !== want.cell_char
							|| rsp.cell_attr !== want.cell_attr
							|| rsp.scrolled !== want.scrolled)
						note_mismatch("response differs", want, rsp);
				end
			end
			rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Fill the request list, release reset, wait for the last response
	initial begin
		int t, rw, cl, kind, n, k, trm, rr, rc, stop_at;

		for (t = 0; t < TERMS; t++) begin
			shadow_row[t] = 0;
			shadow_col[t] = 0;
			for (rw = 0; rw < ROWS; rw++)
				for (cl = 0; cl < COLS; cl++)
					shadow_chars[t][rw][cl] = CHAR_BLANK;
		end

		// Directed: extremes, every command, corner cases
		queue_item(CMD_READ, 0, 0, 0, 0);
		queue_item(CMD_READ, 0, 0, ROWS - 1, COLS - 1);
		queue_item(CMD_BACK, 0, 0, 0, 0);
		queue_item(CMD_PUT, 0, 8'hFF, 0, 0);
		queue_item(CMD_PUT, 0, 8'h00, 0, 0);
		queue_item(CMD_PUT, 1, 8'h41, 0, 0);
		queue_item(CMD_PUT, 2, 8'h7E, 0, 0);
		queue_item(CMD_BACK, 2, 0, 0, 0);
		queue_item(CMD_PUT, 0, CHAR_NL, 0, 0);
		queue_item(CMD_PUT, 0, CHAR_CR, 0, 0);
		queue_item(CMD_BACK, 0, 0, 0, 0);
		queue_item(CMD_READ, 0, 0, 0, 0);
		queue_item(CMD_READ, 0, 0, 0, 1);
		queue_item(CMD_READ, 0, 0, 1, COLS - 1);
		queue_item(CMD_CLEAR, 1, 0, 0, 0);
		queue_item(CMD_READ, 1, 0, 0, 0);
		queue_item(CMD_READ, 0, 0, ROWS, 0);
		queue_item(CMD_READ, 0, 0, 0, COLS);
		queue_item(CMD_READ, 0, 8'hFF, 31, 127);
		queue_item(CMD_READ, 3, 8'hFF, 31, 127);
		queue_item(CMD_PUT, 3, 8'h55, 0, 0);
		queue_item(CMD_CLEAR, 3, 0, 0, 0);
		queue_item(CMD_PUT, 2, 8'h80, 31, 127);

		// Random: sequences of text, newlines, backspaces, reads, clears and noise
		stop_at = pending_reqs.size() + RANDOM_REQS;
		while (pending_reqs.size() < stop_at) begin
			kind = $urandom_range(0, 15);
			trm = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, TERMS - 1);
			if (kind <= 5 || kind == 12) begin
				n = (kind == 12) ? $urandom_range(70, 90) : $urandom_range(1, 12);
				for (k = 0; k < n; k++)
					queue_item(CMD_PUT, trm, $urandom_range(0, 255), $urandom_range(0, 31),
						$urandom_range(0, 127));
				if ($urandom_range(0, 1) == 1)
					queue_item(CMD_PUT, trm, $urandom_range(0, 1) ? CHAR_NL : CHAR_CR,
						$urandom_range(0, 31), $urandom_range(0, 127));
			end else if (kind <= 7) begin
				n = $urandom_range(4, 28);
				for (k = 0; k < n; k++)
					queue_item(CMD_PUT, trm, $urandom_range(0, 3) ? CHAR_NL : CHAR_CR,
						$urandom_range(0, 31), $urandom_range(0, 127));
			end else if (kind <= 9) begin
				n = $urandom_range(1, 8);
				for (k = 0; k < n; k++)
					queue_item(CMD_BACK, trm, $urandom_range(0, 255), $urandom_range(0, 31),
						$urandom_range(0, 127));
			end else if (kind <= 11) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					// Aim mostly at the top rows and the bottom rows where text lands
					case ($urandom_range(0, 9))
						0: begin
							rr = $urandom_range(0, 31);
							rc = $urandom_range(0, 127);
						end
						1: begin
							rr = $urandom_range(0, ROWS - 1);
							rc = $urandom_range(0, COLS - 1);
						end
						default: begin
							rr = $urandom_range(0, 1) ? $urandom_range(0, 3)
								: $urandom_range(ROWS - 4, ROWS - 1);
							rc = $urandom_range(0, 15);
						end
					endcase
					queue_item(CMD_READ, trm, $urandom_range(0, 255), rr, rc);
				end
			end else if (kind == 13) begin
				queue_item(CMD_CLEAR, trm, $urandom_range(0, 255), $urandom_range(0, 31),
					$urandom_range(0, 127));
			end else begin
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++)
					queue_item($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 255),
						$urandom_range(0, 31), $urandom_range(0, 127));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_valid || due_rsps.size() != 0);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== text_console_writer.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_dp.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
verif/text_console_writer_tb.sv
